// ===== rtl/rcsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the satellite frame decoder.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RAW_W       = 11;
   localparam int unsigned ID_W        = 5;
   localparam int unsigned SEL_W       = 4;
   localparam int unsigned ENTRY_W     = 12;
   localparam int unsigned ELAPSED_W   = 16;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;

   localparam logic [RAW_W-1:0]     OFFSET_RESET  = 11'd342;
   localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 16'd1000;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS   = 1'd1;

   // classified request handed from the front to the back
   typedef struct packed {
      logic             is_tick;    // advance elapsed counter
      logic             frame_done; // byte closed a frame
      logic             do_write;   // word carries a valid channel id
      logic [ID_W-1:0]  id;
      logic [RAW_W-1:0] raw;
      logic             sel_ok;     // selected channel exists
      logic [SEL_W-1:0] sel;
   } cmd_type;

endpackage

// ===== rtl/rcsfd_req_if.sv =====
// ----------------------------------------------------------------------------
// rcsfd_req_if
// Request channel: received byte or millisecond tick plus channel select.
// ----------------------------------------------------------------------------
interface rcsfd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic [3:0] channel_select;

   modport source (output valid, output func, output data_byte,
                   output channel_select, input ready);
   modport sink   (input valid, input func, input data_byte,
                   input channel_select, output ready);
endinterface

// ===== rtl/rcsfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rcsfd_rsp_if
// Result channel: frame done, link status and selected channel value.
// ----------------------------------------------------------------------------
interface rcsfd_rsp_if;
   logic              valid;
   logic              ready;
   logic              frame_done;
   logic              link_ok;
   logic signed [11:0] channel_value;

   modport source (output valid, output frame_done, output link_ok,
                   output channel_value, input ready);
   modport sink   (input valid, input frame_done, input link_ok,
                   input channel_value, output ready);
endinterface

// ===== rtl/rc_satellite_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_satellite_frame_decoder
// Satellite receiver serial frame decoder with link timeout monitor.
// ----------------------------------------------------------------------------
// Each request is a received byte or a one millisecond tick, and each request
// returns exactly one result. Bytes are counted into frames of FRAME_BYTES
// with no resynchronization; the first two bytes of a frame are skipped and
// each later byte pair is a big-endian word holding a 5-bit channel id and an
// 11-bit raw value. Ids below CHANNELS load value minus value_offset into the
// channel table, which reset clears. The byte closing a frame clears the
// elapsed counter; ticks advance it, saturating at 65535. link_ok is high
// while elapsed does not exceed timeout_ms. The block takes one request per
// clock while req_ch.ready is high. An accepted request is written into the
// two-entry request queue; the back part pops it once the result register is
// empty or being taken, and loads the result register, which drives rsp_ch.
// Throughput is set by the queue and result register handshake; a stalled
// result channel fills the queue and then drops req_ch.ready.
// Configuration writes are taken at any time the block is idle.
module rc_satellite_frame_decoder
   import rcsfd_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 16,
   parameter int unsigned CHANNELS    = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   rcsfd_req_if.sink             req_ch,
   rcsfd_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RAW_W-1:0]     value_offset_ff, value_offset_in;
   logic [ELAPSED_W-1:0] timeout_ms_ff, timeout_ms_in;

   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   cmd_type q_head_cmd;
   logic    q_full;
   logic    q_empty;

   // decode configuration writes
   always_comb begin
      value_offset_in = value_offset_ff;
      timeout_ms_in   = timeout_ms_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VALUE_OFFSET: value_offset_in = csr_wdata[RAW_W-1:0];
            CSR_TIMEOUT_MS:   timeout_ms_in   = csr_wdata;
            default: begin
               value_offset_in = value_offset_ff;
               timeout_ms_in   = timeout_ms_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_offset_ff <= OFFSET_RESET;
         timeout_ms_ff   <= TIMEOUT_RESET;
      end else begin
         value_offset_ff <= value_offset_in;
         timeout_ms_ff   <= timeout_ms_in;
      end
   end

   // front: track frame position, build the word, classify the request
   rcsfd_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_push_cmd (q_push_cmd)
   );

   // hold classified requests so front and back stall independently
   rcsfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head_cmd (q_head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back: update table and elapsed counter, register the result
   rcsfd_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (q_head_cmd),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .value_offset (value_offset_ff),
      .timeout_ms   (timeout_ms_ff),
      .rsp_ch       (rsp_ch)
   );

endmodule

// ===== rtl/rcsfd_front.sv =====
// ----------------------------------------------------------------------------
// rcsfd_front
// Accepts requests, tracks frame position and assembles channel words.
// ----------------------------------------------------------------------------
module rcsfd_front
   import rcsfd_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = 16,
   parameter int unsigned CHANNELS    = 9
) (
   input  logic             clock,
   input  logic             reset,
   rcsfd_req_if.sink        req_ch,
   input  logic             q_full,
   output logic             q_push,
   output cmd_type          q_push_cmd
);

   localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   logic [IDX_W-1:0]  byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0] high_byte_ff, high_byte_in;
   logic              accept;
   logic              is_byte;
   logic              body_byte;
   logic              last_byte;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_byte      = !req_ch.func;
   assign body_byte    = (byte_index_ff >= IDX_W'(2));
   assign last_byte    = (byte_index_ff == LAST_IDX);

   always_comb begin
      byte_index_in = byte_index_ff;
      high_byte_in  = high_byte_ff;
      if (accept && is_byte) begin
         if (body_byte && !byte_index_ff[0]) begin
            high_byte_in = req_ch.data_byte;
         end
         byte_index_in = last_byte ? '0 : byte_index_ff + IDX_W'(1);
      end
   end

   always_comb begin
      q_push               = accept;
      q_push_cmd.is_tick    = req_ch.func;
      q_push_cmd.frame_done = is_byte && last_byte;
      q_push_cmd.id         = high_byte_ff[BYTE_W-1 -: ID_W];
      q_push_cmd.raw        = {high_byte_ff[RAW_W-BYTE_W-1:0], req_ch.data_byte};
      q_push_cmd.do_write   = is_byte && body_byte && byte_index_ff[0]
                              && ({1'b0, high_byte_ff[BYTE_W-1 -: ID_W]}
                                  < (ID_W+1)'(CHANNELS));
      q_push_cmd.sel        = req_ch.channel_select;
      q_push_cmd.sel_ok     = ({2'b00, req_ch.channel_select} < (SEL_W+2)'(CHANNELS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         high_byte_ff  <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
         high_byte_ff  <= high_byte_in;
      end
   end

endmodule

// ===== rtl/rcsfd_queue.sv =====
// ----------------------------------------------------------------------------
// rcsfd_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rcsfd_queue
   import rcsfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rcsfd_back.sv =====
// ----------------------------------------------------------------------------
// rcsfd_back
// Updates the channel table and elapsed counter, registers each result.
// ----------------------------------------------------------------------------
module rcsfd_back
   import rcsfd_pkg::*;
#(
   parameter int unsigned CHANNELS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              head_cmd,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic [RAW_W-1:0]     value_offset,
   input  logic [ELAPSED_W-1:0] timeout_ms,
   rcsfd_rsp_if.source          rsp_ch
);

   localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [ENTRY_W-1:0]   table_ff [CHANNELS];
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 done_ff;
   logic                 link_ff;
   logic [ENTRY_W-1:0]   value_ff, value_in;
   logic [ENTRY_W-1:0]   new_entry;
   logic [CH_W-1:0]      wr_idx;
   logic [CH_W-1:0]      rd_idx;
   logic                 wr_en;

   assign q_pop  = !q_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign wr_en  = q_pop && head_cmd.do_write;
   assign wr_idx = CH_W'(head_cmd.id);
   assign rd_idx = CH_W'({1'b0, head_cmd.sel});

   assign new_entry = {1'b0, head_cmd.raw} - {1'b0, value_offset};

   always_comb begin
      elapsed_in = elapsed_ff;
      if (q_pop) begin
         if (head_cmd.is_tick) begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + ELAPSED_W'(1);
            end
         end else if (head_cmd.frame_done) begin
            elapsed_in = '0;
         end
      end
   end

   // forward a same-item write to the read port
   always_comb begin
      value_in = '0;
      if (head_cmd.sel_ok) begin
         if (head_cmd.do_write && (wr_idx == rd_idx)) begin
            value_in = new_entry;
         end else begin
            value_in = table_ff[rd_idx];
         end
      end
   end

   always_comb begin
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            table_ff[i] <= '0;
         end
      end else if (wr_en) begin
         table_ff[wr_idx] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         done_ff  <= head_cmd.frame_done;
         link_ff  <= (elapsed_in <= timeout_ms);
         value_ff <= value_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.frame_done    = done_ff;
   assign rsp_ch.link_ok       = link_ff;
   assign rsp_ch.channel_value = signed'(value_ff);

endmodule
